### src/thi_pkg.sv
// Package for the timestamped history interpolator.
// Field widths, payload types and action codes. No dependencies.
`default_nettype none
package thi_pkg;
  localparam int TIME_W = 63;
  localparam int POS_W  = 32;
  localparam int FRAC_W = 16;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [TIME_W-1:0]        sample_time;
    logic signed [POS_W-1:0]  left_position;
    logic signed [POS_W-1:0]  right_position;
    logic [TIME_W-1:0]        query_ns;
  } in_item_t;

  typedef struct packed {
    logic                     found;
    logic signed [POS_W-1:0]  left_at_capture;
    logic signed [POS_W-1:0]  right_at_capture;
  } out_item_t;
endpackage
`default_nettype wire

### src/thi_if.sv
// Valid/ready channel interfaces for the interpolator.
// Depends on thi_pkg.
`default_nettype none
interface thi_in_if import thi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface thi_out_if import thi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/timestamped_history_interpolator_unit.sv
// Top level: timestamp ring, scan sequencer, single compare, shared multiplier.
// Depends on thi_pkg, thi_if, thi_ram.
//
// channel  dir  handshake    payload
// in       in   valid/ready  action, sample_time, left/right_position, query_ns
// out      out  valid/ready  found, left_at_capture, right_at_capture
//
// A push is written to the ring and in_ready stays high. A query compares
// n entries (1 to DEPTH) from the oldest on, reading RAM entries one at a
// time through one compare; to interpolate it then reads the entry before
// and takes the differences, the fraction takes 16 restoring-division steps
// and the blend uses one 33x18 multiplier twice. An empty ring answers with
// found low. Reset clears state, write slot, fill count and out_valid only.
// in_ready is low while an item is at work or a result waits.
`default_nettype none
module timestamped_history_interpolator_unit import thi_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  thi_in_if.sink    in_ch,
  thi_out_if.source out_ch
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PLD   = 4'd4;
  localparam logic [3:0] S_DIF   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ML    = 4'd7;
  localparam logic [3:0] S_MR    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_DIRECT = 4'd11;

  logic [3:0]  state_r;
  logic [AW-1:0] wslot_r, raddr_r;
  logic [CW-1:0] fill_r, k_r;
  logic [TIME_W-1:0] cap_r, ta_r, tb_r;
  logic [TIME_W:0] num_r, den_r;
  logic [FRAC_W-1:0] q_r;
  logic [4:0] step_r;
  logic signed [POS_W-1:0] la_r, ra_r, lb_r, rb_r, lo_r, ro_r;
  logic found_r, ovalid_r;

  logic we;
  logic [TIME_W-1:0] t_rd;
  logic [POS_W-1:0] l_rd, r_rd;

  assign we = in_ch.valid && in_ch.ready && in_ch.data.action == ACT_PUSH;

  thi_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time (
    .clk, .we, .waddr(wslot_r), .wdata(in_ch.data.sample_time),
    .raddr(raddr_r), .rdata(t_rd));
  thi_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_left (
    .clk, .we, .waddr(wslot_r), .wdata(in_ch.data.left_position),
    .raddr(raddr_r), .rdata(l_rd));
  thi_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_right (
    .clk, .we, .waddr(wslot_r), .wdata(in_ch.data.right_position),
    .raddr(raddr_r), .rdata(r_rd));

  // ring index arithmetic without relying on power-of-two depth
  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  logic [CW:0] old_sum;
  logic [AW-1:0] oldest;
  always_comb begin
    old_sum = {1'b0, CW'(wslot_r)} + {1'b0, DEPTH_C} - {1'b0, fill_r};
    oldest = (old_sum >= {1'b0, DEPTH_C}) ? AW'(old_sum - {1'b0, DEPTH_C})
                                          : AW'(old_sum);
  end

  // shared multiplier: 33-bit signed diff times 16-bit unsigned fraction
  logic signed [POS_W:0]   mul_d;
  logic signed [POS_W-1:0] mul_b;
  logic signed [POS_W+FRAC_W+1:0] prod;
  logic signed [POS_W+FRAC_W+1:0] shq;
  always_comb begin
    mul_b = (state_r == S_ML) ? lb_r : rb_r;
    mul_d = (state_r == S_ML) ? (POS_W+1)'(la_r) - (POS_W+1)'(lb_r)
                              : (POS_W+1)'(ra_r) - (POS_W+1)'(rb_r);
    prod  = mul_d * $signed({2'b0, q_r});
    shq   = prod >>> FRAC_W; // arithmetic shift floors
  end

  logic [TIME_W:0] trial;
  assign trial = {num_r[TIME_W-1:0], 1'b0} - den_r;

  assign in_ch.ready  = state_r == S_IDLE && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data.found = found_r;
  assign out_ch.data.left_at_capture  = lo_r;
  assign out_ch.data.right_at_capture = ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wslot_r  <= '0;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          if (in_ch.data.action == ACT_PUSH) begin
            wslot_r <= inc_idx(wslot_r);
            if (fill_r != DEPTH_C) fill_r <= fill_r + 1'b1;
          end else if (fill_r == '0) begin
            found_r <= 1'b0; lo_r <= '0; ro_r <= '0; ovalid_r <= 1'b1;
          end else begin
            cap_r <= in_ch.data.query_ns;
            raddr_r <= oldest;
            k_r <= '0;
            found_r <= 1'b1;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (t_rd > cap_r) begin
            if (k_r == '0) begin
              lo_r <= l_rd; ro_r <= r_rd; state_r <= S_OUT;
            end else begin
              ta_r <= t_rd; la_r <= l_rd; ra_r <= r_rd;
              raddr_r <= dec_idx(raddr_r);
              state_r <= S_PRD;
            end
          end else if (k_r == fill_r - 1'b1) begin
            // none later: current entry is the newest
            lo_r <= l_rd; ro_r <= r_rd; state_r <= S_OUT;
          end else begin
            k_r <= k_r + 1'b1;
            raddr_r <= inc_idx(raddr_r);
            state_r <= S_RD;
          end
        end
        S_PRD: state_r <= S_PLD;
        S_PLD: begin
          tb_r <= t_rd; lb_r <= l_rd; rb_r <= r_rd;
          state_r <= S_DIF;
        end
        S_DIF: begin
          num_r <= {1'b0, cap_r - tb_r};
          den_r <= {1'b0, ta_r - tb_r};
          q_r <= '0; step_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!trial[TIME_W]) begin
            num_r <= trial; q_r <= {q_r[FRAC_W-2:0], 1'b1};
          end else begin
            num_r <= {num_r[TIME_W-1:0], 1'b0}; q_r <= {q_r[FRAC_W-2:0], 1'b0};
          end
          step_r <= step_r + 1'b1;
          if (step_r == 5'(FRAC_W - 1)) state_r <= S_ML;
        end
        S_ML: begin lo_r <= mul_b + POS_W'(shq); state_r <= S_MR; end
        S_MR: begin ro_r <= mul_b + POS_W'(shq); state_r <= S_FIN; end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin ovalid_r <= 1'b1; state_r <= S_IDLE; end
        S_DIRECT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fill never exceeds depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= DEPTH_C)
    else $error("fill count above depth");
  // no new item while a result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  // a push never yields a result
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.action == ACT_PUSH && !out_ch.valid)
      |=> !out_ch.valid) else $error("result after push");
endmodule
`default_nettype wire

### src/thi_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module thi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
